FILE: sv/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define LMSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define LMSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds through reset
`define LMSP_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/lmsp_pkg.sv
package lmsp_pkg;

  // default geometry
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 16;
  localparam int FRAME_COUNT_DEF = 4;

  // field widths
  localparam int FRAME_W = 2;
  localparam int X_W     = 7;
  localparam int Y_W     = 4;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 3;

  // request kinds carried on s_tuser
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_REQUEST = 2'd2
  } action_t;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_COLUMNS = 3'd0,
    CFG_ROWS    = 3'd1,
    CFG_RED     = 3'd2,
    CFG_GREEN   = 3'd3,
    CFG_CLOCK   = 3'd4,
    CFG_ENABLE  = 3'd5,
    CFG_LATCH   = 3'd6
  } cfg_index_t;

  // register reset values
  localparam logic [7:0] COLUMNS_RST = 8'd128;
  localparam logic [4:0] ROWS_RST    = 5'd16;
  localparam logic [2:0] RED_RST     = 3'd3;
  localparam logic [2:0] GREEN_RST   = 3'd4;
  localparam logic [2:0] CLOCK_RST   = 3'd5;
  localparam logic [2:0] ENABLE_RST  = 3'd6;
  localparam logic [2:0] LATCH_RST   = 3'd7;

  typedef struct packed {
    logic [7:0] columns;
    logic [4:0] rows;
    logic [2:0] red_bit;
    logic [2:0] green_bit;
    logic [2:0] clock_bit;
    logic [2:0] enable_bit;
    logic [2:0] latch_bit;
  } cfg_t;

  // which byte of a row is being built
  typedef enum logic [1:0] {
    BYTE_START = 2'd0,
    BYTE_DATA  = 2'd1,
    BYTE_END   = 2'd2
  } byte_kind_t;

  // scan stage to emit stage
  typedef struct packed {
    byte_kind_t kind;
    logic [2:0] sel;
    logic       clock;
    logic       d_line;
  } slot_t;

endpackage

FILE: sv/lmsp_ram.sv
module lmsp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lmsp_scan.sv
module lmsp_scan #(
  parameter int MAX_COLUMNS = lmsp_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lmsp_pkg::MAX_ROWS_DEF,
  parameter int FRAME_COUNT = lmsp_pkg::FRAME_COUNT_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  lmsp_pkg::cfg_t                                   cfg,
  input  logic                                             s_valid,
  output logic                                             s_ready,
  input  logic [1:0]                                       action,
  input  logic [lmsp_pkg::FRAME_W-1:0]                     frame_index,
  input  logic [lmsp_pkg::X_W-1:0]                         pixel_x,
  input  logic [lmsp_pkg::Y_W-1:0]                         pixel_y,
  input  logic                                             red_on,
  input  logic                                             green_on,
  input  logic                                             slot_ready,
  output logic                                             slot_valid,
  output lmsp_pkg::slot_t                                  slot,
  output logic                                             ram_we,
  output logic [$clog2(FRAME_COUNT*MAX_ROWS*MAX_COLUMNS)-1:0] ram_waddr,
  output logic [1:0]                                       ram_wdata,
  output logic                                             ram_re,
  output logic [$clog2(FRAME_COUNT*MAX_ROWS*MAX_COLUMNS)-1:0] ram_raddr
);

  localparam int DEPTH  = FRAME_COUNT * MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int WCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int POS_W  = $clog2(2 * MAX_COLUMNS + 2);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);

  // scan state
  logic [ROW_W-1:0]              scan_row;
  logic [POS_W-1:0]              scan_position;
  logic                          d_line_state;
  logic [lmsp_pkg::FRAME_W-1:0]  live_frame;
  logic [lmsp_pkg::FRAME_W-1:0]  pending_frame;
  logic                          frame_pending;

  // clearing pass
  logic                          clr_busy;
  logic [ADDR_W-1:0]             clr_addr;

  logic [ROW_W-1:0]              scan_row_next;
  logic [POS_W-1:0]              scan_position_next;
  logic                          boundary;

  logic [WCNT_W-1:0]             w_eff;
  logic [RCNT_W-1:0]             r_eff;
  logic [POS_W-1:0]              last;
  logic [ROW_W-1:0]              row_c;
  logic [POS_W-1:0]              pos_c;
  logic [COL_W-1:0]              rd_col;
  logic [RCNT_W-1:0]             row_inc;
  logic [3:0]                    wr_row;
  logic [lmsp_pkg::X_W-1:0]      wr_col;
  logic                          wr_ok;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          accept;
  logic                          is_write;
  logic                          is_tick;
  logic                          is_request;
  lmsp_pkg::slot_t               slot_next;

  // request decode
  always_comb begin
    is_write   = 1'b0;
    is_tick    = 1'b0;
    is_request = 1'b0;
    unique case (action)
      lmsp_pkg::ACT_WRITE:   is_write   = 1'b1;
      lmsp_pkg::ACT_TICK:    is_tick    = 1'b1;
      lmsp_pkg::ACT_REQUEST: is_request = 1'b1;
      default: ;
    endcase
  end

  assign s_ready = !clr_busy && (!slot_valid || slot_ready);
  assign accept  = s_valid && s_ready;

  // effective geometry from the registers
  always_comb begin
    if (cfg.columns == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(cfg.columns) > MAX_COLUMNS) begin
      w_eff = WCNT_W'(MAX_COLUMNS);
    end else begin
      w_eff = WCNT_W'(cfg.columns);
    end
    if (32'(cfg.rows) > MAX_ROWS) begin
      r_eff = RCNT_W'(MAX_ROWS);
    end else begin
      r_eff = RCNT_W'(cfg.rows);
    end
    r_eff[0] = 1'b0;
    if (r_eff < RCNT_W'(2)) begin
      r_eff = RCNT_W'(2);
    end
  end

  assign last = POS_W'({w_eff, 1'b1});

  // pixel write address
  assign wr_row  = 4'(r_eff) - 4'd2 - pixel_y;
  assign wr_col  = 7'd127 - pixel_x;
  assign wr_ok   = (32'(frame_index) < FRAME_COUNT) && (32'(wr_row) < MAX_ROWS) &&
                   (32'(wr_col) < MAX_COLUMNS);
  assign wr_addr = ADDR_W'((32'(frame_index) * MAX_ROWS + 32'(wr_row)) * MAX_COLUMNS +
                           32'(wr_col));

  // tick: byte kind, read address and scan advance
  always_comb begin
    row_c   = (RCNT_W'(scan_row) >= r_eff) ? '0 : scan_row;
    pos_c   = (scan_position > last) ? last : scan_position;
    rd_col  = COL_W'((pos_c - POS_W'(1)) >> 1);
    row_inc = RCNT_W'(row_c) + RCNT_W'(1);

    slot_next.sel    = 3'(row_c);
    slot_next.clock  = !pos_c[0];
    slot_next.d_line = d_line_state;
    if (pos_c == '0) begin
      slot_next.kind = lmsp_pkg::BYTE_START;
    end else if (pos_c == last) begin
      slot_next.kind = lmsp_pkg::BYTE_END;
    end else begin
      slot_next.kind = lmsp_pkg::BYTE_DATA;
    end

    boundary = 1'b0;
    if (pos_c == last) begin
      scan_position_next = '0;
      boundary = (row_inc == (r_eff >> 1)) || (row_inc == r_eff);
      scan_row_next = (row_inc >= r_eff) ? '0 : ROW_W'(row_inc);
    end else begin
      scan_position_next = pos_c + POS_W'(1);
      scan_row_next      = row_c;
    end
  end

  // store port usage
  assign ram_we    = clr_busy || (accept && is_write && wr_ok);
  assign ram_waddr = clr_busy ? clr_addr : wr_addr;
  assign ram_wdata = clr_busy ? 2'b00 : {green_on, red_on};
  assign ram_re    = accept && is_tick;
  assign ram_raddr = ADDR_W'((32'(live_frame) * MAX_ROWS + 32'(row_c)) * MAX_COLUMNS +
                             32'(rd_col));

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // scan and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row      <= '0;
      scan_position <= '0;
      d_line_state  <= 1'b0;
      live_frame    <= '0;
      pending_frame <= '0;
      frame_pending <= 1'b0;
    end else if (accept) begin
      if (is_tick) begin
        scan_row      <= scan_row_next;
        scan_position <= scan_position_next;
        if (boundary) begin
          d_line_state <= !d_line_state;
          if (frame_pending) begin
            live_frame    <= pending_frame;
            frame_pending <= 1'b0;
          end
        end
      end
      if (is_request && (32'(frame_index) < FRAME_COUNT)) begin
        pending_frame <= frame_index;
        frame_pending <= 1'b1;
      end
    end
  end

  // stage register toward the emit stage
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (accept && is_tick) begin
      slot_valid <= 1'b1;
    end else if (slot_ready) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      slot <= slot_next;
    end
  end

endmodule

FILE: sv/lmsp_emit.sv
module lmsp_emit (
  input  logic            clk,
  input  logic            rst,
  input  lmsp_pkg::cfg_t  cfg,
  input  logic            slot_valid,
  input  lmsp_pkg::slot_t slot,
  input  logic [1:0]      pixel,
  output logic            slot_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [7:0]      pattern_byte,
  output logic            d_line
);

  logic [7:0] pattern_next;

  assign slot_ready = !out_valid || out_ready;

  // pin pattern assembly
  always_comb begin
    pattern_next = {5'b00000, slot.sel};
    case (slot.kind)
      lmsp_pkg::BYTE_START: begin
        pattern_next = pattern_next | (8'd1 << cfg.enable_bit) | (8'd1 << cfg.latch_bit);
      end
      lmsp_pkg::BYTE_END: begin
        pattern_next = pattern_next | (8'd1 << cfg.enable_bit);
      end
      lmsp_pkg::BYTE_DATA: begin
        if (pixel[0]) begin
          pattern_next = pattern_next | (8'd1 << cfg.red_bit);
        end
        if (pixel[1]) begin
          pattern_next = pattern_next | (8'd1 << cfg.green_bit);
        end
        if (slot.clock) begin
          pattern_next = pattern_next | (8'd1 << cfg.clock_bit);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_ready) begin
      out_valid <= slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ready && slot_valid) begin
      pattern_byte <= pattern_next;
      d_line       <= slot.d_line;
    end
  end

endmodule

FILE: sv/led_matrix_scan_pattern_generator.sv
// a tick's pattern byte passes the scan stage register, then the emit result register
// throughput: one request per cycle unless stalled; store has one write and one read port
// pixel writes and frame requests produce no output byte
// reset: s_tready stays low while all FRAME_COUNT*MAX_ROWS*MAX_COLUMNS store entries
// (8192 by default) are cleared; configuration writes are taken throughout
module led_matrix_scan_pattern_generator #(
  parameter int MAX_COLUMNS = lmsp_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lmsp_pkg::MAX_ROWS_DEF,
  parameter int FRAME_COUNT = lmsp_pkg::FRAME_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // frame_index[1:0], pixel_x[8:2], pixel_y[12:9], red_on[13], green_on[14]
  input  logic [15:0]                   s_tdata,
  // action[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pattern_byte[7:0], d_line[8]
  output logic [15:0]                   m_tdata,
  input  logic                          cfg_write,
  input  logic [lmsp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lmsp_pkg::CFG_W-1:0]    cfg_data
);

  localparam int DEPTH  = FRAME_COUNT * MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  lmsp_pkg::cfg_t  cfg;
  lmsp_pkg::slot_t slot;
  logic            slot_valid;
  logic            slot_ready;
  logic            ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [1:0]      ram_wdata;
  logic            ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [1:0]      ram_rdata;
  logic [7:0]      pattern_byte;
  logic            d_line;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns    <= lmsp_pkg::COLUMNS_RST;
      cfg.rows       <= lmsp_pkg::ROWS_RST;
      cfg.red_bit    <= lmsp_pkg::RED_RST;
      cfg.green_bit  <= lmsp_pkg::GREEN_RST;
      cfg.clock_bit  <= lmsp_pkg::CLOCK_RST;
      cfg.enable_bit <= lmsp_pkg::ENABLE_RST;
      cfg.latch_bit  <= lmsp_pkg::LATCH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lmsp_pkg::CFG_COLUMNS: cfg.columns    <= cfg_data;
        lmsp_pkg::CFG_ROWS:    cfg.rows       <= cfg_data[4:0];
        lmsp_pkg::CFG_RED:     cfg.red_bit    <= cfg_data[2:0];
        lmsp_pkg::CFG_GREEN:   cfg.green_bit  <= cfg_data[2:0];
        lmsp_pkg::CFG_CLOCK:   cfg.clock_bit  <= cfg_data[2:0];
        lmsp_pkg::CFG_ENABLE:  cfg.enable_bit <= cfg_data[2:0];
        lmsp_pkg::CFG_LATCH:   cfg.latch_bit  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  lmsp_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lmsp_scan #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .action      (s_tuser),
    .frame_index (s_tdata[1:0]),
    .pixel_x     (s_tdata[8:2]),
    .pixel_y     (s_tdata[12:9]),
    .red_on      (s_tdata[13]),
    .green_on    (s_tdata[14]),
    .slot_ready  (slot_ready),
    .slot_valid  (slot_valid),
    .slot        (slot),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  lmsp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .slot_valid   (slot_valid),
    .slot         (slot),
    .pixel        (ram_rdata),
    .slot_ready   (slot_ready),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .pattern_byte (pattern_byte),
    .d_line       (d_line)
  );

  assign m_tdata = {7'b0000000, d_line, pattern_byte};

endmodule

FILE: sv/lmsp_checker.sv
`include "assert_macros.svh"

module lmsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // store is being cleared right after reset
  `LMSP_ASSERT_RST(a_ready_low_after_reset, clk, rst, !s_tready)

  // no output byte straight out of reset
  `LMSP_ASSERT_RST(a_no_output_after_reset, clk, rst, !m_tvalid)

  // a new output byte comes from an accepted tick, through the scan stage and emit registers
  `LMSP_ASSERT_IMP(a_output_from_tick, clk, rst, $rose(m_tvalid),
    $past(s_tvalid && s_tready && (s_tuser == lmsp_pkg::ACT_TICK), 2))

  // a stalled output byte holds
  `LMSP_ASSERT_NXT(a_output_holds, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata))

endmodule

bind led_matrix_scan_pattern_generator lmsp_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
